// File: sv/afp_pkg.sv
// Shared types, codes and helpers for the animation frame player.
`timescale 1ns / 1ps

package afp_pkg;

  // Field widths
  localparam int POS_W = 24;                // Q16.8 position
  localparam int SPD_W = 16;                // signed Q8.8 speed
  localparam int VAL_W = 25;                // signed request value
  localparam int F_W   = 27;                // signed working position
  localparam int MAG_W = 25;                // remainder dividend magnitude
  localparam int CNT_W = $clog2(MAG_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int AFP_FRAC_BITS = 8;

  localparam logic [POS_W-1:0]        POS_MAX = {POS_W{1'b1}};
  localparam logic signed [SPD_W-1:0] SPD_MAX = {1'b0, {(SPD_W-1){1'b1}}};
  localparam logic signed [SPD_W-1:0] SPD_MIN = {1'b1, {(SPD_W-1){1'b0}}};
  localparam logic [SPD_W-1:0]        INIT_SPEED_RESET = 16'd256;

  // Operation codes
  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_SET_POS   = 2'd1;
  localparam logic [1:0] OP_SET_SPEED = 2'd2;
  localparam logic [1:0] OP_RESTART   = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_REJECT  = 2'd1;
  localparam logic [1:0] STAT_NO_CLIP = 2'd2;

  // Loop modes
  localparam logic [2:0] MODE_ONCE     = 3'd0;
  localparam logic [2:0] MODE_RESET    = 3'd1;
  localparam logic [2:0] MODE_LOOP     = 3'd2;
  localparam logic [2:0] MODE_REVERSE  = 3'd3;
  localparam logic [2:0] MODE_LOOP_REV = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LOADED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_POS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SPEED = 3'd4;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHECK,
    ST_REV_CHECK,
    ST_DIV,
    ST_MOD_FIX,
    ST_COMMIT,
    ST_OUT
  } ctrl_state_t;

  // Datapath commands
  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_NO_CLIP,
    ACT_REJECT,
    ACT_SET_POS,
    ACT_SET_SPEED,
    ACT_RESTART,
    ACT_SUM,
    ACT_ONCE,
    ACT_STOP_START,
    ACT_WRAP_EMPTY,
    ACT_DIV_START,
    ACT_DIV_STEP,
    ACT_MOD_FIX,
    ACT_REFLECT_END,
    ACT_REFLECT_START,
    ACT_COMMIT,
    ACT_OUTPUT
  } dp_act_t;

  // Datapath status toward the controller
  typedef struct packed {
    logic [1:0] op;
    logic [2:0] mode;
    logic       clip_loaded;
    logic       halted;
    logic       val_pos_ok;
    logic       val_spd_ok;
    logic       range_ok;
    logic       f_lt_st;
    logic       f_ge_en;
    logic       div_last;
    logic       out_free;
  } dp_stat_t;

  // Clamp a working position into the position code range
  function automatic logic [POS_W-1:0] sat_pos(input logic signed [F_W-1:0] f);
    logic [POS_W-1:0] r;
    if (f < 0) begin
      r = '0;
    end else if (f > $signed(F_W'(POS_MAX))) begin
      r = POS_MAX;
    end else begin
      r = f[POS_W-1:0];
    end
    return r;
  endfunction

  // Negate a speed, saturating the most negative code
  function automatic logic signed [SPD_W-1:0] neg_speed(input logic signed [SPD_W-1:0] s);
    logic signed [SPD_W-1:0] r;
    if (s == SPD_MIN) begin
      r = SPD_MAX;
    end else begin
      r = -s;
    end
    return r;
  endfunction

endpackage

// File: sv/afp_ctrl.sv
// Sequencing state machine of the animation frame player.
`timescale 1ns / 1ps

module afp_ctrl
  import afp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_act_t  act
);

  ctrl_state_t state, state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Choose the next state and the datapath command
  always_comb begin
    state_next = state;
    act        = ACT_NONE;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        // Refuse beats while reset is held
        in_stall = rst;
        if (in_valid && !rst) begin
          act        = ACT_LOAD;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_OUT;
        unique case (stat.op)
          OP_TICK: begin
            if (!stat.clip_loaded) begin
              act = ACT_NO_CLIP;
            end else if (!stat.halted) begin
              act        = ACT_SUM;
              state_next = ST_CHECK;
            end
          end
          OP_SET_POS: begin
            if (!stat.clip_loaded) begin
              act = ACT_NO_CLIP;
            end else if (stat.val_pos_ok) begin
              act = ACT_SET_POS;
            end else begin
              act = ACT_REJECT;
            end
          end
          OP_SET_SPEED: begin
            act = stat.val_spd_ok ? ACT_SET_SPEED : ACT_REJECT;
          end
          OP_RESTART: begin
            act = stat.range_ok ? ACT_RESTART : ACT_REJECT;
          end
        endcase
      end
      ST_CHECK: begin
        state_next = ST_COMMIT;
        if (stat.f_lt_st || stat.f_ge_en) begin
          unique case (stat.mode)
            MODE_ONCE:  act = ACT_ONCE;
            MODE_RESET: act = ACT_STOP_START;
            MODE_LOOP: begin
              if (stat.range_ok) begin
                act        = ACT_DIV_START;
                state_next = ST_DIV;
              end else begin
                act = ACT_WRAP_EMPTY;
              end
            end
            MODE_REVERSE: begin
              if (stat.f_ge_en) begin
                act        = ACT_REFLECT_END;
                state_next = ST_REV_CHECK;
              end else begin
                act = ACT_STOP_START;
              end
            end
            MODE_LOOP_REV: begin
              act = stat.f_ge_en ? ACT_REFLECT_END : ACT_REFLECT_START;
            end
            default: act = ACT_REJECT;
          endcase
        end
      end
      ST_REV_CHECK: begin
        // Stop if the reflection landed below the start
        if (stat.f_lt_st) begin
          act = ACT_STOP_START;
        end
        state_next = ST_COMMIT;
      end
      ST_DIV: begin
        act = ACT_DIV_STEP;
        if (stat.div_last) begin
          state_next = ST_MOD_FIX;
        end
      end
      ST_MOD_FIX: begin
        act        = ACT_MOD_FIX;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        act        = ACT_COMMIT;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          act        = ACT_OUTPUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Checks
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && !stat.div_last) |=> state == ST_DIV)
    else $error("remainder loop left early");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && stat.div_last) |=> state == ST_MOD_FIX)
    else $error("remainder loop did not end");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == ST_DECODE)
    else $error("accepted beat not decoded");

endmodule

// File: sv/afp_dp.sv
// Datapath of the animation frame player: config, playback state, remainder unit, result.
`timescale 1ns / 1ps

module afp_dp
  import afp_pkg::*;
#(
  parameter int FRAC_BITS = AFP_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic [1:0]                  op,
  input  logic signed [VAL_W-1:0]     value,
  input  dp_act_t                     act,
  output dp_stat_t                    stat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [POS_W-1:0]            position,
  output logic signed [SPD_W-1:0]     speed_now,
  output logic                        halted,
  output logic                        wrapped,
  output logic                        reflected,
  output logic                        stop_event
);

  localparam logic [POS_W-1:0] END_RESET = POS_W'(64'd1 << FRAC_BITS);

  // Configuration registers
  logic             clip_loaded;
  logic [2:0]       play_mode;
  logic [POS_W-1:0] start_pos;
  logic [POS_W-1:0] end_pos;
  logic [SPD_W-1:0] init_speed;

  // Playback state
  logic [POS_W-1:0]        pos;
  logic signed [SPD_W-1:0] spd;
  logic                    halt_flag;

  // Per-beat working registers
  logic [1:0]              op_r;
  logic signed [VAL_W-1:0] val_r;
  logic signed [F_W-1:0]   f;
  logic signed [SPD_W-1:0] s;
  logic [1:0]              res_status;
  logic                    wr, rf, se;

  // Remainder unit
  logic [MAG_W-1:0] mag;
  logic [POS_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             neg;

  logic signed [F_W-1:0] st_x, en_x, val_x, spd_x, d;
  logic [POS_W-1:0]      span, rem_fix;
  logic [MAG_W-1:0]      trial;

  assign st_x  = F_W'(start_pos);
  assign en_x  = F_W'(end_pos);
  assign val_x = F_W'(val_r);
  assign spd_x = F_W'(spd);
  assign span  = end_pos - start_pos;
  assign d     = f - st_x;
  assign trial = {rem, mag[MAG_W-1]};
  assign rem_fix = (neg && rem != '0) ? span - rem : rem;

  // Report conditions to the controller
  always_comb begin
    stat.op          = op_r;
    stat.mode        = play_mode;
    stat.clip_loaded = clip_loaded;
    stat.halted      = halt_flag;
    stat.val_pos_ok  = (val_x >= st_x) && (val_x < en_x);
    stat.val_spd_ok  = (val_r[VAL_W-1:SPD_W-1] == '0) || (val_r[VAL_W-1:SPD_W-1] == '1);
    stat.range_ok    = start_pos < end_pos;
    stat.f_lt_st     = f < st_x;
    stat.f_ge_en     = f >= en_x;
    stat.div_last    = cnt == '0;
    stat.out_free    = !out_valid || !out_stall;
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_loaded <= 1'b0;
      play_mode   <= MODE_ONCE;
      start_pos   <= '0;
      end_pos     <= END_RESET;
      init_speed  <= INIT_SPEED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLIP_LOADED:   clip_loaded <= cfg_data[0];
        CFG_LOOP_MODE:     play_mode   <= cfg_data[2:0];
        CFG_START_POS:     start_pos   <= cfg_data[POS_W-1:0];
        CFG_END_POS:       end_pos     <= cfg_data[POS_W-1:0];
        CFG_INITIAL_SPEED: init_speed  <= cfg_data[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // Update playback state and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      spd        <= '0;
      halt_flag  <= 1'b1;
      res_status <= STAT_OK;
      wr         <= 1'b0;
      rf         <= 1'b0;
      se         <= 1'b0;
    end else begin
      case (act)
        ACT_LOAD: begin
          res_status <= STAT_OK;
          wr         <= 1'b0;
          rf         <= 1'b0;
          se         <= 1'b0;
        end
        ACT_NO_CLIP: res_status <= STAT_NO_CLIP;
        ACT_REJECT:  res_status <= STAT_REJECT;
        ACT_SET_POS: pos <= val_r[POS_W-1:0];
        ACT_SET_SPEED: begin
          spd       <= val_r[SPD_W-1:0];
          halt_flag <= val_r[SPD_W-1:0] == '0;
        end
        ACT_RESTART: begin
          pos       <= start_pos;
          spd       <= init_speed;
          halt_flag <= init_speed == '0;
        end
        ACT_ONCE, ACT_STOP_START: begin
          halt_flag <= 1'b1;
          se        <= 1'b1;
        end
        ACT_WRAP_EMPTY, ACT_MOD_FIX: wr <= 1'b1;
        ACT_REFLECT_END, ACT_REFLECT_START: begin
          rf <= 1'b1;
          wr <= play_mode == MODE_LOOP_REV;
        end
        ACT_COMMIT: begin
          pos <= sat_pos(f);
          spd <= s;
        end
        default: ;
      endcase
    end
  end

  // Working position, working speed and the remainder unit
  always_ff @(posedge clk) begin
    case (act)
      ACT_LOAD: begin
        op_r  <= op;
        val_r <= value;
      end
      ACT_SUM: begin
        f <= F_W'(pos) + spd_x;
        s <= spd;
      end
      ACT_ONCE: begin
        f <= (s < 0) ? st_x : en_x - F_W'(1);
        s <= '0;
      end
      ACT_STOP_START: begin
        f <= st_x;
        s <= '0;
      end
      ACT_WRAP_EMPTY: f <= st_x;
      ACT_REFLECT_END: begin
        f <= (en_x <<< 1) - f;
        s <= neg_speed(s);
      end
      ACT_REFLECT_START: begin
        f <= (st_x <<< 1) - f;
        s <= neg_speed(s);
      end
      ACT_DIV_START: begin
        neg <= d < 0;
        mag <= (d < 0) ? MAG_W'(-d) : MAG_W'(d);
        rem <= '0;
        cnt <= CNT_W'(MAG_W - 1);
      end
      ACT_DIV_STEP: begin
        // One restoring step: shift in a dividend bit, subtract when it fits
        if (trial >= {1'b0, span}) begin
          rem <= POS_W'(trial - {1'b0, span});
        end else begin
          rem <= trial[POS_W-1:0];
        end
        mag <= mag << 1;
        cnt <= cnt - CNT_W'(1);
      end
      ACT_MOD_FIX: f <= st_x + F_W'(rem_fix);
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (act == ACT_OUTPUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act == ACT_OUTPUT) begin
      status     <= res_status;
      position   <= pos;
      speed_now  <= spd;
      halted     <= halt_flag;
      wrapped    <= wr;
      reflected  <= rf;
      stop_event <= se;
    end
  end

  // Checks
  a_stop_halts: assert property (@(posedge clk) disable iff (rst)
    se |-> halt_flag)
    else $error("stop event without halt");

  a_flags_tick: assert property (@(posedge clk) disable iff (rst)
    (wr || rf || se) |-> op_r == OP_TICK)
    else $error("tick flag on a non-tick beat");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    $past(act == ACT_DIV_STEP) |-> rem < span)
    else $error("remainder not below span");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    act == ACT_OUTPUT |-> (!out_valid || !out_stall))
    else $error("result overwritten while held");

endmodule

// File: sv/animation_frame_player_top.sv
// Top level of the animation frame player.
`timescale 1ns / 1ps

// Animation frame player: keeps an unsigned Q16.8 playback position, a signed
// Q8.8 speed and a halted flag, and serves one request per input beat (tick,
// set position, set speed, restart), giving one result beat for each. The
// block works on one request at a time. Set position, set speed, restart,
// refused requests and ticks that find playback halted or no clip go from
// decode straight to output; a tick that runs passes check and commit, plus
// a check of a reverse-mode reflection against the start. A loop-mode wrap
// runs a 25-step restoring remainder against the span (one dividend bit per
// cycle) and a modulo fix before commit. A new request can be accepted in the
// same cycle that the result is raised; the output register lets it enter
// while that result waits, but its own result holds until the receiver takes
// the first. The user must write configuration through cfg_we, cfg_index and
// cfg_data only while no request is in progress; the block does not check it.
module animation_frame_player_top
  import afp_pkg::*;
#(
  parameter int FRAC_BITS = AFP_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              op,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              status,
  output logic [POS_W-1:0]        position,
  output logic signed [SPD_W-1:0] speed_now,
  output logic                    halted,
  output logic                    wrapped,
  output logic                    reflected,
  output logic                    stop_event
);

  dp_act_t  act;
  dp_stat_t stat;

  afp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .act      (act)
  );

  afp_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .op         (op),
    .value      (value),
    .act        (act),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .position   (position),
    .speed_now  (speed_now),
    .halted     (halted),
    .wrapped    (wrapped),
    .reflected  (reflected),
    .stop_event (stop_event)
  );

endmodule
